// ----- rtl/core/jts_pkg.sv -----
// Shared types, constants and helper functions for the JSON token scanner.
`default_nettype none

package jts_pkg;

  // Default width of the internal byte position counter.
  localparam int POSITION_BITS = 32;

  // Width of the positions carried on the result stream.
  localparam int OUT_POS_BITS = 32;

  // Number of token bundles buffered between the scanner and the output stage.
  localparam int QUEUE_DEPTH = 2;

  // Most tokens that a single byte can produce.
  localparam int MAX_TOKENS = 3;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_VALUE   = 3'd0,
    MODE_LITERAL = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_DRAIN   = 3'd5
  } scan_mode_t;

  // Token kinds as they appear on the result stream.
  typedef enum logic [3:0] {
    KIND_LBRACKET = 4'd0,
    KIND_RBRACKET = 4'd1,
    KIND_LBRACE   = 4'd2,
    KIND_RBRACE   = 4'd3,
    KIND_COLON    = 4'd4,
    KIND_COMMA    = 4'd5,
    KIND_NULL     = 4'd6,
    KIND_FALSE    = 4'd7,
    KIND_TRUE     = 4'd8,
    KIND_STRING   = 4'd9,
    KIND_NUMBER   = 4'd10,
    KIND_DONE     = 4'd11,
    KIND_ERROR    = 4'd12
  } token_kind_t;

  // Literal selectors.
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_TRUE  = 2'd2;

  // One token as produced by the scanner.
  typedef struct packed {
    token_kind_t             kind;
    logic [OUT_POS_BITS-1:0] first;
    logic [OUT_POS_BITS-1:0] last;
  } token_t;

  // All tokens caused by one byte; cnt is the number of valid entries.
  typedef struct packed {
    logic [1:0]                  cnt;
    token_t [MAX_TOKENS-1:0]     toks;
  } bundle_t;

  // Letters of each literal after its first letter.
  function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (which)
      LIT_NULL: begin
        case (idx)
          2'd0: ch = "u";
          2'd1: ch = "l";
          2'd2: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          2'd0: ch = "a";
          2'd1: ch = "l";
          2'd2: ch = "s";
          default: ch = "e";
        endcase
      end
      LIT_TRUE: begin
        case (idx)
          2'd0: ch = "r";
          2'd1: ch = "u";
          2'd2: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Number of letters that follow the first letter of each literal.
  function automatic logic [2:0] lit_len(input logic [1:0] which);
    logic [2:0] len;
    case (which)
      LIT_NULL:  len = 3'd3;
      LIT_FALSE: len = 3'd4;
      LIT_TRUE:  len = 3'd3;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Builds one token.
  function automatic token_t make_token(input token_kind_t kind,
                                        input logic [OUT_POS_BITS-1:0] first,
                                        input logic [OUT_POS_BITS-1:0] last);
    token_t t;
    t.kind  = kind;
    t.first = first;
    t.last  = last;
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jts_front.sv -----
// Scanner front end: accepts text bytes, tracks lexer state and builds token bundles.
`default_nettype none

module jts_front #(
  parameter int POSITION_BITS = jts_pkg::POSITION_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       in_byte,
  input  wire logic             text_end,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  push,
  output jts_pkg::bundle_t      push_data,
  input  wire logic             queue_full
);

  // Scanner state.
  jts_pkg::scan_mode_t      mode, mode_next;
  logic [1:0]               lit_which, lit_which_next;
  logic [2:0]               lit_index, lit_index_next;
  logic [POSITION_BITS-1:0] start_pos, start_pos_next;
  logic [POSITION_BITS-1:0] byte_pos, byte_pos_next;

  // Value-start decode of the current byte.
  logic                     sv_emit;
  jts_pkg::token_kind_t     sv_kind;
  jts_pkg::scan_mode_t      sv_mode;
  logic                     sv_start;
  logic                     sv_lit;
  logic [1:0]               sv_which;

  logic                     accept;
  logic                     is_num_char;
  logic                     run_value;
  logic [2:0]               lit_step;
  logic [1:0]               n;
  jts_pkg::bundle_t         bundle;

  logic [jts_pkg::OUT_POS_BITS-1:0] pos_out, pos_prev_out, pos_inc_out;
  logic [jts_pkg::OUT_POS_BITS-1:0] start_out, start_next_out;

  // Maps an internal position to the width carried on the result stream.
  function automatic logic [jts_pkg::OUT_POS_BITS-1:0] to_out(
      input logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+jts_pkg::OUT_POS_BITS-1:0] w;
    w = {{jts_pkg::OUT_POS_BITS{1'b0}}, p};
    return w[jts_pkg::OUT_POS_BITS-1:0];
  endfunction

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign pos_out        = to_out(byte_pos);
  assign pos_prev_out   = to_out(byte_pos - POSITION_BITS'(1));
  assign pos_inc_out    = to_out(byte_pos + POSITION_BITS'(1));
  assign start_out      = to_out(start_pos);
  assign start_next_out = to_out(start_pos_next);

  assign is_num_char = (in_byte inside {["0":"9"], "e", "E", ".", "+", "-"});

  // Classify the byte as if it stood where a value may start.
  always_comb begin
    sv_emit  = 1'b0;
    sv_kind  = jts_pkg::KIND_ERROR;
    sv_mode  = jts_pkg::MODE_VALUE;
    sv_start = 1'b0;
    sv_lit   = 1'b0;
    sv_which = jts_pkg::LIT_NULL;
    case (in_byte)
      "[": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_LBRACKET; end
      "]": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_RBRACKET; end
      "{": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_LBRACE; end
      "}": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_RBRACE; end
      ":": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_COLON; end
      ",": begin sv_emit = 1'b1; sv_kind = jts_pkg::KIND_COMMA; end
      8'h09, 8'h0A, 8'h0D, 8'h20: begin
        sv_mode = jts_pkg::MODE_VALUE;
      end
      "n", "f", "t": begin
        sv_mode  = jts_pkg::MODE_LITERAL;
        sv_start = 1'b1;
        sv_lit   = 1'b1;
        sv_which = (in_byte == "n") ? jts_pkg::LIT_NULL :
                   (in_byte == "f") ? jts_pkg::LIT_FALSE : jts_pkg::LIT_TRUE;
      end
      "\"": begin
        sv_mode  = jts_pkg::MODE_STRING;
        sv_start = 1'b1;
      end
      default: begin
        if (in_byte inside {["0":"9"], "-"}) begin
          sv_mode  = jts_pkg::MODE_NUMBER;
          sv_start = 1'b1;
        end else begin
          sv_emit = 1'b1;
          sv_kind = jts_pkg::KIND_ERROR;
          sv_mode = jts_pkg::MODE_DRAIN;
        end
      end
    endcase
  end

  // Next state and the tokens caused by the accepted byte.
  always_comb begin
    mode_next      = mode;
    lit_which_next = lit_which;
    lit_index_next = lit_index;
    start_pos_next = start_pos;
    byte_pos_next  = byte_pos;
    run_value      = 1'b0;
    lit_step       = lit_index + 3'd1;
    n              = 2'd0;
    bundle         = '0;

    if (accept) begin
      case (mode)
        jts_pkg::MODE_VALUE: begin
          run_value = 1'b1;
        end
        jts_pkg::MODE_LITERAL: begin
          if (lit_index < jts_pkg::lit_len(lit_which) &&
              in_byte == jts_pkg::lit_char(lit_which, lit_index[1:0])) begin
            lit_index_next = lit_step;
            if (lit_step == jts_pkg::lit_len(lit_which)) begin
              bundle.toks[n] = jts_pkg::make_token(
                  jts_pkg::token_kind_t'(jts_pkg::KIND_NULL + {2'b00, lit_which}),
                  start_out, pos_out);
              n = n + 2'd1;
              mode_next = jts_pkg::MODE_VALUE;
            end
          end else begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_ERROR, start_out, pos_out);
            n = n + 2'd1;
            mode_next = jts_pkg::MODE_DRAIN;
          end
        end
        jts_pkg::MODE_STRING: begin
          if (in_byte == "\"") begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_STRING, start_out, pos_out);
            n = n + 2'd1;
            mode_next = jts_pkg::MODE_VALUE;
          end else if (in_byte == "\\") begin
            mode_next = jts_pkg::MODE_ESCAPE;
          end
        end
        jts_pkg::MODE_ESCAPE: begin
          mode_next = jts_pkg::MODE_STRING;
        end
        jts_pkg::MODE_NUMBER: begin
          // A byte that cannot continue the number closes it and is rescanned.
          if (!is_num_char) begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_NUMBER, start_out,
                                                 pos_prev_out);
            n = n + 2'd1;
            run_value = 1'b1;
          end
        end
        default: begin
          mode_next = jts_pkg::MODE_DRAIN;
        end
      endcase

      // Apply the value-start decode where the byte opens a new token.
      if (run_value) begin
        mode_next = sv_mode;
        if (sv_emit) begin
          bundle.toks[n] = jts_pkg::make_token(sv_kind, pos_out, pos_out);
          n = n + 2'd1;
        end
        if (sv_start) begin
          start_pos_next = byte_pos;
        end
        if (sv_lit) begin
          lit_which_next = sv_which;
          lit_index_next = 3'd0;
        end
      end

      byte_pos_next = byte_pos + POSITION_BITS'(1);

      // End of text: close what is open, then return to the reset state.
      if (text_end) begin
        case (mode_next)
          jts_pkg::MODE_VALUE: begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_DONE, pos_inc_out,
                                                 pos_inc_out);
            n = n + 2'd1;
          end
          jts_pkg::MODE_NUMBER: begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_NUMBER, start_next_out,
                                                 pos_out);
            n = n + 2'd1;
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_DONE, pos_inc_out,
                                                 pos_inc_out);
            n = n + 2'd1;
          end
          jts_pkg::MODE_LITERAL, jts_pkg::MODE_STRING, jts_pkg::MODE_ESCAPE: begin
            bundle.toks[n] = jts_pkg::make_token(jts_pkg::KIND_ERROR, start_next_out,
                                                 pos_out);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
        mode_next      = jts_pkg::MODE_VALUE;
        lit_which_next = jts_pkg::LIT_NULL;
        lit_index_next = 3'd0;
        start_pos_next = '0;
        byte_pos_next  = '0;
      end
    end

    bundle.cnt = n;
  end

  assign push      = accept && (n != 2'd0);
  assign push_data = bundle;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jts_pkg::MODE_VALUE;
      lit_which <= jts_pkg::LIT_NULL;
      lit_index <= 3'd0;
      start_pos <= '0;
      byte_pos  <= '0;
    end else begin
      mode      <= mode_next;
      lit_which <= lit_which_next;
      lit_index <= lit_index_next;
      start_pos <= start_pos_next;
      byte_pos  <= byte_pos_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jts_queue.sv -----
// Small register queue of token bundles between the scanner and the output stage.
`default_nettype none

module jts_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jts_pkg::bundle_t push_data,
  output logic                full,
  input  wire logic           pop,
  output jts_pkg::bundle_t    pop_data,
  output logic                not_empty
);

  localparam int AW = (jts_pkg::QUEUE_DEPTH > 1) ? $clog2(jts_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(jts_pkg::QUEUE_DEPTH + 1);

  jts_pkg::bundle_t entries [jts_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(jts_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage is written only; it needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(jts_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(jts_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jts_back.sv -----
// Output stage: unpacks token bundles and sends one token per transfer.
`default_nettype none

module jts_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire jts_pkg::bundle_t        q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output jts_pkg::token_t              out_token,
  output logic                         out_last
);

  jts_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             fire;

  assign out_valid = cur_valid;
  assign out_token = cur.toks[idx];
  assign out_last  = (idx == cur.cnt - 2'd1);
  assign fire      = cur_valid && out_ready;

  // Take the next bundle when the holding register is empty or about to empty.
  assign q_pop = q_valid && (!cur_valid || (fire && out_last));

  // Bundle holding register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Valid flag and token index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (out_last) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/json_token_scanner_core.sv -----
// Top level of the JSON token scanner: scanner front end, bundle queue and output stage.
//
//   channel  direction  tdata                                  tuser       tlast
//   s_*      in         [7:0] in_byte                          -           text_end
//   m_*      out        [31:0] token_start, [63:32] token_end  token_kind  run_last
//
// One text byte is taken per cycle while the bundle queue has room; the scanner
// state is a single register stage, so consecutive bytes never wait on each other.
// Each byte yields zero to three tokens; the output stage sends one token per cycle
// while m_tready is high. A byte that closes a number and ends the text can yield
// three tokens. A token passes through the bundle queue and then the output stage's
// holding register before it is offered on m_*.
// Reset is synchronous and empties the queue and returns the scanner to value start.
// A stall on m_* fills the queue (two bundles) and then holds s_tready low.
`default_nettype none

module json_token_scanner_core #(
  parameter int POSITION_BITS = jts_pkg::POSITION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // text_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] token_start, [63:32] token_end
  output logic [3:0]       m_tuser,   // [3:0] token_kind
  output logic             m_tlast    // run_last
);

  logic             push;
  jts_pkg::bundle_t push_data;
  logic             queue_full;
  logic             pop;
  jts_pkg::bundle_t pop_data;
  logic             queue_valid;
  jts_pkg::token_t  token;

  // Scanner front end.
  jts_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .text_end  (s_tlast),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .push      (push),
    .push_data (push_data),
    .queue_full(queue_full)
  );

  // Bundle queue.
  jts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .pop_data (pop_data),
    .not_empty(queue_valid)
  );

  // Output stage.
  jts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (queue_valid),
    .q_data   (pop_data),
    .q_pop    (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_token(token),
    .out_last (m_tlast)
  );

  // Pack the token onto the result stream.
  assign m_tdata = {token.last, token.first};
  assign m_tuser = token.kind;

endmodule

`default_nettype wire
